>>> hw/rtl/brbd_pkg.sv
// Shared types and helpers for the Bayer RGGB bilinear demosaic core.
// No dependencies.
package brbd_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } brbd_state_t;

    // Command from controller to datapath.
    typedef struct packed {
        logic       capture;  // take a sample, start line store read
        logic       update;   // write line store, shift window, step counters
        logic       load;     // load one output pixel into the output register
        logic [1:0] slot;     // which pixel: bit0 last column, bit1 last row
        logic       run_end;  // last pixel for this sample
    } brbd_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [3:0] mask;     // pixels due for the captured sample
        logic       out_free; // output register can take a word
    } brbd_sts_t;

    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;
    localparam logic        REG_FRAME_WIDTH  = 1'b0;
    localparam logic        REG_FRAME_HEIGHT = 1'b1;

    // Rounded mean of 1..4 terms: (sum + cnt/2) / cnt. Divide by 3 uses 683/2048.
    function automatic logic [7:0] avg(input logic [9:0] sum, input logic [2:0] cnt);
        logic [20:0] prod;
        logic [10:0] s1;
        logic [11:0] s2;
        logic [7:0]  res;
        s1   = {1'b0, sum} + 11'd1;
        s2   = {2'b0, sum} + 12'd2;
        prod = 21'(s1) * 21'd683;
        case (cnt)
            3'd1:    res = sum[7:0];
            3'd2:    res = s1[8:1];
            3'd3:    res = prod[18:11];
            3'd4:    res = s2[9:2];
            default: res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

>>> hw/rtl/brbd_ctrl.sv
// Sequencer for the demosaic core: fetch, update, then emit pixels one a cycle while the output register is free.
// Depends on brbd_pkg.
module brbd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  brbd_pkg::brbd_sts_t sts,
    output brbd_pkg::brbd_cmd_t cmd
);
    import brbd_pkg::*;

    brbd_state_t state_reg, state_next;
    logic [3:0]  mask_reg, mask_next;
    logic [3:0]  low_bit;
    logic [3:0]  rest;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mask_reg  <= 4'd0;
        end else begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
        end
    end

    assign low_bit = mask_reg & (~mask_reg + 4'd1);
    assign rest    = mask_reg & ~low_bit;

    always_comb begin
        state_next  = state_reg;
        mask_next   = mask_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.update = 1'b1;
                mask_next  = sts.mask;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (mask_reg == 4'd0) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.load    = 1'b1;
                    cmd.slot[0] = low_bit[1] | low_bit[3];
                    cmd.slot[1] = low_bit[2] | low_bit[3];
                    cmd.run_end = (rest == 4'd0);
                    mask_next   = rest;
                    if (rest == 4'd0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/brbd_datapath.sv
// Datapath: config registers, line store, 3x3 window, counters, color means,
// output register. Depends on brbd_pkg.
module brbd_datapath #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [7:0]        s_raw_sample,
    input  brbd_pkg::brbd_cmd_t cmd,
    output brbd_pkg::brbd_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_red,
    output logic [7:0]        m_green,
    output logic [7:0]        m_blue,
    output logic [11:0]       m_out_column,
    output logic [15:0]       m_out_row,
    output logic              m_run_end,
    output logic              m_frame_end
);
    import brbd_pkg::*;

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    logic [12:0]   fw_reg;
    logic [15:0]   fh_reg;
    logic [CW-1:0] wl;
    logic [15:0]   hl;

    // Line store: {upper, middle} per column.
    logic [15:0]   line_mem [0:MAX_WIDTH-1];
    logic [15:0]   rd_reg;
    logic [7:0]    smp_reg;
    logic [CW-1:0] col_reg, ccur_reg;
    logic [15:0]   row_reg, rcur_reg;
    logic [7:0]    win_reg [0:2][0:2];

    logic          valid_reg;
    logic [7:0]    red_reg, green_reg, blue_reg;
    logic [11:0]   xo_reg;
    logic [15:0]   yo_reg;
    logic          run_reg, fend_reg;

    // Config and derived frame limits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg <= cfg_data[12:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (fw_reg < 13'd2) begin
            wl = CW'(1);
        end else if (32'(fw_reg) > MAX_WIDTH) begin
            wl = CW'(MAX_WIDTH - 1);
        end else begin
            wl = CW'(fw_reg - 13'd1);
        end
        hl = (fh_reg < 16'd2) ? 16'd1 : fh_reg - 16'd1;
    end

    // Line store
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_reg  <= line_mem[col_reg];
            smp_reg <= s_raw_sample;
        end
        if (cmd.update) begin
            line_mem[ccur_reg] <= {rd_reg[7:0], smp_reg};
        end
    end

    // Counters and window
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            col_reg  <= '0;
            row_reg  <= '0;
            ccur_reg <= '0;
            rcur_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= 8'd0;
                end
            end
        end else begin
            if (cmd.capture) begin
                ccur_reg <= col_reg;
                rcur_reg <= row_reg;
            end
            if (cmd.update) begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= rd_reg[15:8];
                win_reg[1][2] <= rd_reg[7:0];
                win_reg[2][2] <= smp_reg;
                if (ccur_reg == wl) begin
                    col_reg <= '0;
                    row_reg <= (rcur_reg == hl) ? 16'd0 : rcur_reg + 16'd1;
                end else begin
                    col_reg <= ccur_reg + CW'(1);
                end
            end
        end
    end

    logic c_ge1, r_ge1, c_last, r_last;
    assign c_ge1  = (ccur_reg != '0);
    assign r_ge1  = (rcur_reg != 16'd0);
    assign c_last = (ccur_reg == wl);
    assign r_last = (rcur_reg == hl);
    assign sts = '{
        mask:     {r_last & c_last, r_last & c_ge1, r_ge1 & c_last, r_ge1 & c_ge1},
        out_free: !valid_reg || m_ready
    };

    // Pixel selection and means
    logic [CW-1:0] x;
    logic [15:0]   y;
    logic [1:0]    pc, pr;
    logic [7:0]    px [0:3][0:3];
    logic          lo, ro, to, bo;
    logic [7:0]    ctr, nv, sv, wv, ev, nw, ne, sw, se;
    logic [9:0]    ax_s, dg_s, hz_s, vt_s;
    logic [2:0]    ax_c, dg_c, hz_c, vt_c;
    logic [7:0]    ax_m, dg_m, hz_m, vt_m;
    logic [7:0]    r_v, g_v, b_v;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                px[i][j] = (i < 3 && j < 3) ? win_reg[i % 3][j % 3] : 8'd0;
            end
        end
        x  = cmd.slot[0] ? wl : ccur_reg - CW'(1);
        pc = cmd.slot[0] ? 2'd2 : 2'd1;
        y  = cmd.slot[1] ? rcur_reg : rcur_reg - 16'd1;
        pr = cmd.slot[1] ? 2'd2 : 2'd1;
        lo = (x != '0);
        ro = (x != wl);
        to = (y != 16'd0);
        bo = (y != hl);
        ctr = px[pr][pc];
        nv  = to ? px[pr - 2'd1][pc] : 8'd0;
        sv  = bo ? px[pr + 2'd1][pc] : 8'd0;
        wv  = lo ? px[pr][pc - 2'd1] : 8'd0;
        ev  = ro ? px[pr][pc + 2'd1] : 8'd0;
        nw  = (to && lo) ? px[pr - 2'd1][pc - 2'd1] : 8'd0;
        ne  = (to && ro) ? px[pr - 2'd1][pc + 2'd1] : 8'd0;
        sw  = (bo && lo) ? px[pr + 2'd1][pc - 2'd1] : 8'd0;
        se  = (bo && ro) ? px[pr + 2'd1][pc + 2'd1] : 8'd0;
        hz_s = 10'(wv) + 10'(ev);
        vt_s = 10'(nv) + 10'(sv);
        ax_s = hz_s + vt_s;
        dg_s = 10'(nw) + 10'(ne) + 10'(sw) + 10'(se);
        hz_c = 3'(lo) + 3'(ro);
        vt_c = 3'(to) + 3'(bo);
        ax_c = hz_c + vt_c;
        dg_c = 3'(to && lo) + 3'(to && ro) + 3'(bo && lo) + 3'(bo && ro);
        ax_m = avg(ax_s, ax_c);
        dg_m = avg(dg_s, dg_c);
        hz_m = avg(hz_s, hz_c);
        vt_m = avg(vt_s, vt_c);
        if (!x[0] && !y[0]) begin
            r_v = ctr;  g_v = ax_m; b_v = dg_m;
        end else if (x[0] && y[0]) begin
            r_v = dg_m; g_v = ax_m; b_v = ctr;
        end else if (!y[0]) begin
            r_v = hz_m; g_v = ctr;  b_v = vt_m;
        end else begin
            r_v = vt_m; g_v = ctr;  b_v = hz_m;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            red_reg   <= r_v;
            green_reg <= g_v;
            blue_reg  <= b_v;
            xo_reg    <= 12'(x);
            yo_reg    <= y;
            run_reg   <= cmd.run_end;
            fend_reg  <= (x == wl) && (y == hl);
        end
    end

    assign m_valid      = valid_reg;
    assign m_red        = red_reg;
    assign m_green      = green_reg;
    assign m_blue       = blue_reg;
    assign m_out_column = xo_reg;
    assign m_out_row    = yo_reg;
    assign m_run_end    = run_reg;
    assign m_frame_end  = fend_reg;

endmodule

>>> hw/rtl/bayer_rggb_bilinear_demosaic_core.sv
// Top level of the RGGB Bayer bilinear demosaic core.
// Depends on brbd_pkg, brbd_ctrl and brbd_datapath.
//
// Raw 8-bit samples enter in raster order on s_*; RGB pixels leave on m_* with
// column, row, run_end (last pixel caused by a sample) and frame_end marks.
// A pixel is sent once its lower-right neighbor has arrived; the last row goes
// out as it arrives. Each sample takes a line store read, then an update,
// then one emit step per pixel it releases (0 to 4), or one empty emit step
// if it releases none. A typical sample releases one pixel, the last sample of
// a row two, and the last sample of a row in the last row four; output stalls
// stretch the emit steps. The line store has a single port read and written
// once per sample. Writing frame_width or frame_height through cfg_* restarts
// the frame; write only while idle. No clearing pass: stale line store entries
// only feed positions outside the frame.
module bayer_rggb_bilinear_demosaic_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_raw_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [11:0] m_out_column,
    output logic [15:0] m_out_row,
    output logic        m_run_end,
    output logic        m_frame_end
);
    import brbd_pkg::*;

    brbd_cmd_t cmd;
    brbd_sts_t sts;

    // Sequencer: one sample at a time, one output word per cycle while the output register is free.
    brbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage, window and color interpolation.
    brbd_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_raw_sample (s_raw_sample),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_out_column (m_out_column),
        .m_out_row    (m_out_row),
        .m_run_end    (m_run_end),
        .m_frame_end  (m_frame_end)
    );

endmodule

>>> verif/tb_bayer_rggb_bilinear_demosaic_core.sv
// Self-checking testbench for bayer_rggb_bilinear_demosaic_core.
// Depends on brbd_pkg and the core RTL. It predicts every RGB word from the raw
// stream with its own line-store model and checks the words in order.
module tb_bayer_rggb_bilinear_demosaic_core;
    timeunit 1ns;
    timeprecision 1ps;
    import brbd_pkg::*;

    localparam int LINE_DEPTH = 4096;

    // Neighbor patterns used by the interpolator.
    typedef enum int {NB_AXIAL, NB_DIAG, NB_HORIZ, NB_VERT} nb_kind_t;

    typedef struct {
        bit [7:0]  red;
        bit [7:0]  green;
        bit [7:0]  blue;
        bit [11:0] column;
        bit [15:0] row;
        bit        run_end;
        bit        frame_end;
    } rgb_word_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_raw_sample;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [11:0] m_out_column;
    logic [15:0] m_out_row;
    logic        m_run_end;
    logic        m_frame_end;

    bayer_rggb_bilinear_demosaic_core #(.MAX_WIDTH(LINE_DEPTH)) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_raw_sample (s_raw_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_out_column (m_out_column),
        .m_out_row    (m_out_row),
        .m_run_end    (m_run_end),
        .m_frame_end  (m_frame_end)
    );

    // ---------------------------------------------------------------
    // Shadow of the core state
    // ---------------------------------------------------------------
    bit [12:0]   shadow_width;
    bit [15:0]   shadow_height;
    bit [7:0]    shadow_upper [LINE_DEPTH];
    bit [7:0]    shadow_middle[LINE_DEPTH];
    bit [7:0]    shadow_win[9];
    int unsigned shadow_col;
    int unsigned shadow_row;

    bit [7:0]  raw_pending[$];   // samples waiting for the driver
    rgb_word_t rgb_expected[$];  // predicted pixels, oldest first
    int        error_count = 0;

    // Idling controls shared with the initial block.
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    bit rx_long_hold_req = 1'b0;

    function automatic int eff_w();
        if (shadow_width < 2) return 2;
        if (shadow_width > LINE_DEPTH) return LINE_DEPTH;
        return int'(shadow_width);
    endfunction

    function automatic int eff_h();
        if (shadow_height < 2) return 2;
        return int'(shadow_height);
    endfunction

    function automatic void frame_restart();
        foreach (shadow_win[i]) shadow_win[i] = '0;
        shadow_col = 0;
        shadow_row = 0;
    endfunction

    // Window covers columns cc-2..cc and rows rr-2..rr.
    function automatic bit win_fetch(int nx, int ny, int cc, int rr, output int v);
        int wc, wr;
        v  = 0;
        wc = nx - (cc - 2);
        wr = ny - (rr - 2);
        if (nx < 0 || ny < 0 || nx >= eff_w() || ny >= eff_h()) return 1'b0;
        if (wc < 0 || wc > 2 || wr < 0 || wr > 2) return 1'b0;
        v = shadow_win[wr * 3 + wc];
        return 1'b1;
    endfunction

    function automatic bit [7:0] nb_mean(nb_kind_t kind, int x, int y, int cc, int rr);
        int dx[4], dy[4];
        int n, total, cnt, v;
        total = 0;
        cnt   = 0;
        n     = 4;
        case (kind)
            NB_AXIAL: begin
                dx = '{-1, 1, 0, 0}; dy = '{0, 0, -1, 1};
            end
            NB_DIAG: begin
                dx = '{-1, 1, -1, 1}; dy = '{-1, -1, 1, 1};
            end
            NB_HORIZ: begin
                dx = '{-1, 1, 0, 0}; dy = '{0, 0, 0, 0}; n = 2;
            end
            default: begin
                dx = '{0, 0, 0, 0}; dy = '{-1, 1, 0, 0}; n = 2;
            end
        endcase
        for (int i = 0; i < n; i++) begin
            if (win_fetch(x + dx[i], y + dy[i], cc, rr, v)) begin
                total += v;
                cnt++;
            end
        end
        if (cnt == 0) return 8'd0;
        return 8'((total + cnt / 2) / cnt);
    endfunction

    function automatic rgb_word_t interp_pixel(int x, int y, int cc, int rr);
        rgb_word_t p;
        int        center;
        bit        ex, ey;
        ex = (x % 2) == 0;
        ey = (y % 2) == 0;
        void'(win_fetch(x, y, cc, rr, center));
        if (ex && ey) begin
            p.red   = 8'(center);
            p.green = nb_mean(NB_AXIAL, x, y, cc, rr);
            p.blue  = nb_mean(NB_DIAG, x, y, cc, rr);
        end else if (!ex && !ey) begin
            p.red   = nb_mean(NB_DIAG, x, y, cc, rr);
            p.green = nb_mean(NB_AXIAL, x, y, cc, rr);
            p.blue  = 8'(center);
        end else if (ey) begin
            p.green = 8'(center);
            p.red   = nb_mean(NB_HORIZ, x, y, cc, rr);
            p.blue  = nb_mean(NB_VERT, x, y, cc, rr);
        end else begin
            p.green = 8'(center);
            p.red   = nb_mean(NB_VERT, x, y, cc, rr);
            p.blue  = nb_mean(NB_HORIZ, x, y, cc, rr);
        end
        p.column    = 12'(x);
        p.row       = 16'(y);
        p.run_end   = 1'b0;
        p.frame_end = (x == eff_w() - 1) && (y == eff_h() - 1);
        return p;
    endfunction

    // Append one predicted pixel to the expected queue.
    function automatic void expect_word(rgb_word_t p);
        rgb_expected.insert(rgb_expected.size(), p);
    endfunction

    // Append one raw word to the driver queue.
    function automatic void queue_raw(bit [7:0] v);
        raw_pending.insert(raw_pending.size(), v);
    endfunction

    // Advance the shadow by one accepted raw word and queue the pixels it frees.
    function automatic void demosaic_step(bit [7:0] s);
        int        w, h, c, r, n0;
        bit [7:0]  up, mid;
        w  = eff_w();
        h  = eff_h();
        c  = int'(shadow_col);
        r  = int'(shadow_row);
        n0 = rgb_expected.size();
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;
        up  = shadow_upper[c];
        mid = shadow_middle[c];
        shadow_upper[c]  = mid;
        shadow_middle[c] = s;
        for (int i = 0; i < 3; i++) begin
            shadow_win[i * 3]     = shadow_win[i * 3 + 1];
            shadow_win[i * 3 + 1] = shadow_win[i * 3 + 2];
        end
        shadow_win[2] = up;
        shadow_win[5] = mid;
        shadow_win[8] = s;
        // previous row first, then the last row, each left to right
        if (r >= 1) begin
            if (c >= 1) expect_word(interp_pixel(c - 1, r - 1, c, r));
            if (c == w - 1) expect_word(interp_pixel(w - 1, r - 1, c, r));
        end
        if (r == h - 1) begin
            if (c >= 1) expect_word(interp_pixel(c - 1, r, c, r));
            if (c == w - 1) expect_word(interp_pixel(w - 1, r, c, r));
        end
        if (rgb_expected.size() > n0) rgb_expected[rgb_expected.size() - 1].run_end = 1'b1;
        if (c == w - 1) begin
            shadow_col = 0;
            shadow_row = (r == h - 1) ? 0 : r + 1;
        end else begin
            shadow_col = c + 1;
            shadow_row = r;
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Raw word driver
    // ---------------------------------------------------------------
    int tx_gap = 0;

    initial begin
        s_valid      = 1'b0;
        s_raw_sample = '0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) demosaic_step(s_raw_sample);
            // only move on once the current word is taken
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (raw_pending.size() > 0) begin
                    s_raw_sample <= raw_pending.pop_front();
                    s_valid      <= 1'b1;
                    tx_gap        = tx_gaps_on ? pick_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // RGB word monitor and checker
    // ---------------------------------------------------------------
    int rx_hold = 0;

    initial m_ready = 1'b0;

    always @(posedge aclk) begin
        rgb_word_t exp_w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (rgb_expected.size() == 0) begin
                    $error("unexpected pixel at column %0d row %0d", m_out_column, m_out_row);
                    error_count++;
                end else begin
                    exp_w = rgb_expected.pop_front();
                    if (m_red !== exp_w.red) begin
                        $error("red: expected %0d, got %0d", exp_w.red, m_red);
                        error_count++;
                    end
                    if (m_green !== exp_w.green) begin
                        $error("green: expected %0d, got %0d", exp_w.green, m_green);
                        error_count++;
                    end
                    if (m_blue !== exp_w.blue) begin
                        $error("blue: expected %0d, got %0d", exp_w.blue, m_blue);
                        error_count++;
                    end
                    if (m_out_column !== exp_w.column) begin
                        $error("out_column: expected %0d, got %0d", exp_w.column, m_out_column);
                        error_count++;
                    end
                    if (m_out_row !== exp_w.row) begin
                        $error("out_row: expected %0d, got %0d", exp_w.row, m_out_row);
                        error_count++;
                    end
                    if (m_run_end !== exp_w.run_end) begin
                        $error("run_end: expected %0d, got %0d", exp_w.run_end, m_run_end);
                        error_count++;
                    end
                    if (m_frame_end !== exp_w.frame_end) begin
                        $error("frame_end: expected %0d, got %0d",
                               exp_w.frame_end, m_frame_end);
                        error_count++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (rx_long_hold_req) begin
                // long backpressure so the core fills and stalls s_ready
                rx_long_hold_req = 1'b0;
                rx_hold          = 400;
                m_ready <= 1'b0;
            end else begin
                rx_hold = rx_gaps_on ? pick_gap() : 0;
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic wait_drained();
        @(negedge aclk);
        while (raw_pending.size() > 0 || s_valid || rgb_expected.size() > 0)
            @(negedge aclk);
    endtask

    // Wait until idle, let the last sample finish inside the core, then write.
    task automatic write_reg(logic idx, bit [15:0] value);
        wait_drained();
        repeat (20) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FRAME_WIDTH) shadow_width = 13'(value);
        else shadow_height = value;
        frame_restart();
    endtask

    task automatic set_frame(bit [15:0] w, bit [15:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Random raw words, biased toward the ends of the range.
    task automatic push_random(int n);
        int roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) queue_raw(8'h00);
            else if (roll == 1) queue_raw(8'hFF);
            else queue_raw(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_FRAME_WIDTH;
        cfg_data      = '0;
        aresetn       = 1'b0;
        shadow_width  = FRAME_WIDTH_RST;
        shadow_height = FRAME_HEIGHT_RST;
        foreach (shadow_upper[i]) begin
            shadow_upper[i]  = '0;
            shadow_middle[i] = '0;
        end
        frame_restart();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset size 640x480: a short run inside row 0, which releases nothing.
        push_random(20);
        wait_drained();

        // Width and height below range act as 2x2: four tiny frames with checkerboard,
        // all-white, all-black and inverted checkerboard content.
        set_frame(16'd0, 16'd0);
        queue_raw(8'h00); queue_raw(8'hFF);
        queue_raw(8'hFF); queue_raw(8'h00);
        repeat (4) queue_raw(8'hFF);
        repeat (4) queue_raw(8'h00);
        set_frame(16'd1, 16'd1);
        queue_raw(8'hFF); queue_raw(8'h00);
        queue_raw(8'h00); queue_raw(8'hFF);

        // Odd and even sizes, at least one whole frame each.
        set_frame(16'd3, 16'd3);
        push_random(18);
        set_frame(16'd5, 16'd4);
        push_random(20);
        set_frame(16'd2, 16'd5);
        push_random(20);

        // Back-pressure: sender streams without gaps, receiver holds off long.
        set_frame(16'd6, 16'd2);
        tx_gaps_on = 1'b0;
        push_random(24);
        @(negedge aclk);
        rx_long_hold_req = 1'b1;
        wait_drained();
        tx_gaps_on = 1'b1;

        // Stretch without any idling.
        set_frame(16'd7, 16'd3);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        push_random(21);
        wait_drained();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;

        // Tallest frame, with the sender pausing mid frame until all is out.
        set_frame(16'd7, 16'd65535);
        push_random(14);
        wait_drained();
        push_random(14);

        // Widest frame written exactly, then a too-wide value clamped to the
        // line store depth.
        set_frame(16'd4096, 16'd2);
        push_random(10);
        set_frame(16'd8191, 16'd2);
        push_random(10);

        // Leave the core at a mid-size setting.
        set_frame(16'd9, 16'd6);
        push_random(27);

        wait_drained();
        repeat (30) @(posedge aclk);
        if (rgb_expected.size() != 0) begin
            $error("%0d predicted pixels never arrived", rgb_expected.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("bayer_rggb_bilinear_demosaic_core verification clean");
        end else begin
            $display("bayer_rggb_bilinear_demosaic_core verification failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #20ms;
        $display("bayer_rggb_bilinear_demosaic_core verification failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/brbd_pkg.sv
hw/rtl/brbd_ctrl.sv
hw/rtl/brbd_datapath.sv
hw/rtl/bayer_rggb_bilinear_demosaic_core.sv
verif/tb_bayer_rggb_bilinear_demosaic_core.sv
